FILE: rtl/mbs_pkg.sv
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared constants and types of the multipart boundary splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package mbs_pkg;

   localparam int MAX_BOUNDARY_DEF = 56;

   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 3;
   localparam int CNT_W      = 6;
   localparam int LEN_W      = 6;
   localparam int CSR_DATA_W = 64;

   // register index of the token length; token words follow at 1 and up
   localparam int REG_LEN = 0;

   // two pattern bytes (CR LF) are assumed seen at message start
   localparam logic [CNT_W-1:0] MATCH_LEAD = CNT_W'(2);
   // pattern bytes ahead of the token: CR LF '-' '-'
   localparam logic [CNT_W-1:0] PAT_PREFIX = CNT_W'(4);

   localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_DASH = 8'h2D;

   localparam logic [KIND_W-1:0] KIND_HEADER    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BODY      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BOUNDARY  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_HDONE     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLOSE     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_MALFORMED = 3'd5;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic [KIND_W-1:0] kind;
   } result_type;

   typedef struct packed {
      logic              go;
      logic              clear;
      logic              feed;
      logic [BYTE_W-1:0] data;
   } feed_cmd_type;

   typedef struct packed {
      logic hold;
      logic finished;
   } feed_status_type;

endpackage

`default_nettype wire

FILE: rtl/multipart_boundary_splitter.sv
// ----------------------------------------------------------------------------
// multipart_boundary_splitter
// Splits a multipart body, one byte per request, into header, body and
// boundary results using one shared pattern selector and framing engine.
// ----------------------------------------------------------------------------
// Sequencing: each byte is accepted, then matched; a new request is taken only
//   once the previous byte has been matched. A byte that breaks a partial
//   match first releases the held bytes, one step each, and is then matched
//   again; a headers-complete result takes one more framing engine step.
// Results: each passes through a staging slot to rsp_; output stalls hold the sequencer.
// Reset: synchronous; parse state, token length (1) and token (zeros) clear.
`default_nettype none

module multipart_boundary_splitter #(
   parameter int MaxBoundary = mbs_pkg::MAX_BOUNDARY_DEF,
   parameter int CsrAddrW    = $clog2((MaxBoundary + 7) / 8 + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,  // [7:0] data_byte
   input  wire logic                           req_tuser,  // [0] message_start
   // result channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [7:0]                     rsp_tdata,  // [7:0] out_byte
   output logic      [2:0]                     rsp_tuser,  // [2:0] kind
   output logic                                rsp_tlast,
   // configuration
   input  wire logic                           csr_wen,
   input  wire logic [CsrAddrW-1:0]            csr_addr,
   input  wire logic [mbs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CntW = mbs_pkg::CNT_W;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_MATCH  = 4'b0010,
      S_REPLAY = 4'b0100,
      S_FLUSH  = 4'b1000
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [mbs_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic [CntW-1:0]            mcount_ff, mcount_in;
   logic [CntW-1:0]            idx_ff, idx_in;
   logic                       lv_ff, lv_in;

   mbs_pkg::result_type        stage_ff, stage_in;
   logic                       stage_v_ff, stage_v_in;
   logic                       rsp_v_ff, rsp_v_in;
   logic [mbs_pkg::BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [mbs_pkg::KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic                       rsp_last_ff, rsp_last_in;

   mbs_pkg::feed_cmd_type      fcmd;
   mbs_pkg::result_type        fres;
   mbs_pkg::feed_status_type   fstat;
   mbs_pkg::result_type        bnd_res;
   mbs_pkg::result_type        new_res;

   logic [CntW-1:0]            pat_idx;
   logic [mbs_pkg::BYTE_W-1:0] pat_byte;
   logic [CntW-1:0]            plen;
   logic [CntW-1:0]            rep_start;
   logic                       go, hold, hit, mdone, replay_need, accept, flush_now;

   mbs_pattern #(
      .MaxBoundary (MaxBoundary),
      .CsrAddrW    (CsrAddrW)
   ) u_pattern (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rd_idx    (pat_idx),
      .rd_byte   (pat_byte),
      .plen      (plen)
   );

   mbs_feed u_feed (
      .clock  (clock),
      .reset  (reset),
      .cmd    (fcmd),
      .res    (fres),
      .status (fstat)
   );

   // a step may produce one result; it needs the staging slot or a free output
   assign go   = !stage_v_ff || !rsp_v_ff || rsp_tready;
   assign hold = fstat.hold;

   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_FLUSH) && go && !hold);
   assign accept     = req_tvalid && req_tready;

   assign pat_idx     = (state_ff == S_REPLAY) ? idx_ff : mcount_ff;
   assign hit         = (mcount_ff < plen) && (byte_ff == pat_byte);
   assign mdone       = (mcount_ff + CntW'(1)) == plen;
   assign rep_start   = lv_ff ? mbs_pkg::MATCH_LEAD : '0;
   assign replay_need = (mcount_ff != '0) && (rep_start < mcount_ff);
   assign flush_now   = (state_ff == S_FLUSH) && go && !hold && stage_v_ff;

   always_comb begin
      state_in  = state_ff;
      byte_in   = byte_ff;
      mcount_in = mcount_ff;
      idx_in    = idx_ff;
      lv_in     = lv_ff;
      fcmd      = '0;
      fcmd.data = (state_ff == S_REPLAY) ? pat_byte : byte_ff;
      bnd_res   = '{valid: 1'b0, data: '0, kind: mbs_pkg::KIND_BOUNDARY};

      case (state_ff)
         S_IDLE, S_FLUSH: begin
            if (state_ff == S_FLUSH) begin
               fcmd.go = go;
               if (go && !hold) begin
                  state_in = S_IDLE;
               end
            end
            if (accept) begin
               byte_in  = req_tdata;
               state_in = S_MATCH;
               if (req_tuser) begin
                  mcount_in = mbs_pkg::MATCH_LEAD;
                  lv_in     = 1'b1;
                  fcmd.clear = 1'b1;
               end
            end
         end
         S_MATCH: begin
            fcmd.go = go;
            // emit a pending headers-complete before the byte moves on
            if (go && !hold) begin
               state_in = S_FLUSH;
               if (fstat.finished) begin
                  // closed message: ignore the byte
               end else if (hit) begin
                  if (mdone) begin
                     mcount_in     = '0;
                     lv_in         = 1'b0;
                     bnd_res.valid = 1'b1;
                     fcmd.clear    = 1'b1;
                  end else begin
                     mcount_in = mcount_ff + CntW'(1);
                  end
               end else if (replay_need) begin
                  idx_in   = rep_start;
                  state_in = S_REPLAY;
               end else begin
                  // nothing held: the breaking byte goes straight on, but a CR opens a new match
                  lv_in     = 1'b0;
                  fcmd.feed = (byte_ff != mbs_pkg::CHAR_CR);
                  mcount_in = (byte_ff == mbs_pkg::CHAR_CR) ? CntW'(1) : '0;
               end
            end
         end
         S_REPLAY: begin
            fcmd.go   = go;
            fcmd.feed = 1'b1;
            if (go && !hold) begin
               if (({1'b0, idx_ff} + (CntW + 1)'(1)) >= {1'b0, mcount_ff}) begin
                  // release done: rerun the breaking byte with an empty match
                  mcount_in = '0;
                  lv_in     = 1'b0;
                  state_in  = S_MATCH;
               end else begin
                  idx_in = idx_ff + CntW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign new_res = fres.valid ? fres : bnd_res;

   always_comb begin
      stage_in    = stage_ff;
      stage_v_in  = stage_v_ff;
      rsp_v_in    = rsp_v_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_last_in = rsp_last_ff;
      if (new_res.valid) begin
         // advance the staged result, hold the new one until its successor
         if (stage_v_ff) begin
            rsp_v_in    = 1'b1;
            rsp_data_in = stage_ff.data;
            rsp_kind_in = stage_ff.kind;
            rsp_last_in = 1'b0;
         end
         stage_in   = new_res;
         stage_v_in = 1'b1;
      end else if (flush_now) begin
         rsp_v_in    = 1'b1;
         rsp_data_in = stage_ff.data;
         rsp_kind_in = stage_ff.kind;
         rsp_last_in = 1'b1;
         stage_v_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mcount_ff  <= mbs_pkg::MATCH_LEAD;
         lv_ff      <= 1'b1;
         stage_v_ff <= 1'b0;
         rsp_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mcount_ff  <= mcount_in;
         lv_ff      <= lv_in;
         stage_v_ff <= stage_v_in;
         rsp_v_ff   <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      idx_ff      <= idx_in;
      stage_ff    <= stage_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_idle_stage_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !stage_v_ff)
      else $error("result still staged while idle");

   a_mcount_range: assert property (@(posedge clock) disable iff (reset)
      mcount_ff < CntW'(MaxBoundary + 4))
      else $error("match count beyond longest pattern");

   a_replay_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLAY) |-> (idx_ff < mcount_ff))
      else $error("release index past held bytes");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      flush_now |=> (rsp_tvalid && rsp_tlast))
      else $error("final result of a request not marked last");

endmodule

`default_nettype wire

FILE: rtl/mbs_pattern.sv
// ----------------------------------------------------------------------------
// mbs_pattern
// Boundary token registers and the shared pattern byte selector.
// ----------------------------------------------------------------------------
`default_nettype none

module mbs_pattern #(
   parameter int MaxBoundary = mbs_pkg::MAX_BOUNDARY_DEF,
   parameter int CsrAddrW    = 3
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wen,
   input  wire logic [CsrAddrW-1:0]               csr_addr,
   input  wire logic [mbs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic [mbs_pkg::CNT_W-1:0]         rd_idx,
   output logic      [mbs_pkg::BYTE_W-1:0]        rd_byte,
   output logic      [mbs_pkg::CNT_W-1:0]         plen
);

   localparam int WordCnt = (MaxBoundary + 7) / 8;
   localparam int TokDepth = WordCnt * 8;
   localparam int TokIdxW = (TokDepth > 1) ? $clog2(TokDepth) : 1;

   logic [TokDepth-1:0][mbs_pkg::BYTE_W-1:0] tok_ff, tok_in;
   logic [mbs_pkg::LEN_W-1:0]                len_ff, len_in;
   logic [mbs_pkg::CNT_W-1:0]                tok_len;
   logic [mbs_pkg::CNT_W-1:0]                tok_pos;

   always_comb begin
      tok_in = tok_ff;
      len_in = len_ff;
      if (csr_wen) begin
         if (csr_addr == CsrAddrW'(mbs_pkg::REG_LEN)) begin
            len_in = csr_wdata[mbs_pkg::LEN_W-1:0];
         end
         for (int k = 0; k < WordCnt; k++) begin
            if (csr_addr == CsrAddrW'(k + 1)) begin
               tok_in[k*8 +: 8] = csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= mbs_pkg::LEN_W'(1);
         tok_ff <= '0;
      end else begin
         len_ff <= len_in;
         tok_ff <= tok_in;
      end
   end

   // clamp the token length into 1 .. MaxBoundary
   always_comb begin
      if (len_ff == '0) begin
         tok_len = mbs_pkg::CNT_W'(1);
      end else if (len_ff > mbs_pkg::LEN_W'(MaxBoundary)) begin
         tok_len = mbs_pkg::CNT_W'(MaxBoundary);
      end else begin
         tok_len = len_ff;
      end
   end

   assign plen    = tok_len + mbs_pkg::PAT_PREFIX;
   assign tok_pos = rd_idx - mbs_pkg::PAT_PREFIX;

   always_comb begin
      rd_byte = '0;
      if (rd_idx == mbs_pkg::CNT_W'(0)) begin
         rd_byte = mbs_pkg::CHAR_CR;
      end else if (rd_idx == mbs_pkg::CNT_W'(1)) begin
         rd_byte = mbs_pkg::CHAR_LF;
      end else if (rd_idx < mbs_pkg::PAT_PREFIX) begin
         rd_byte = mbs_pkg::CHAR_DASH;
      end else if (tok_pos < mbs_pkg::CNT_W'(MaxBoundary)) begin
         rd_byte = tok_ff[tok_pos[TokIdxW-1:0]];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mbs_feed.sv
// ----------------------------------------------------------------------------
// mbs_feed
// Part framing engine: part start check, header end search, body pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mbs_feed (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mbs_pkg::feed_cmd_type    cmd,
   output mbs_pkg::result_type           res,
   output mbs_pkg::feed_status_type      status
);

   typedef enum logic [4:0] {
      PH_START    = 5'b00001,
      PH_HEADERS  = 5'b00010,
      PH_BODY     = 5'b00100,
      PH_DISCARD  = 5'b01000,
      PH_FINISHED = 5'b10000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] pc_ff, pc_in;
   logic       hold_ff, hold_in;
   logic [mbs_pkg::BYTE_W-1:0] expect_byte;

   assign expect_byte = pc_ff[0] ? mbs_pkg::CHAR_LF : mbs_pkg::CHAR_CR;

   always_comb begin
      phase_in = phase_ff;
      pc_in    = pc_ff;
      hold_in  = hold_ff;
      res      = '0;
      if (cmd.clear) begin
         phase_in = PH_START;
         pc_in    = 2'd0;
         hold_in  = 1'b0;
      end else if (cmd.go && hold_ff) begin
         // second result of the byte that closed the headers
         res     = '{valid: 1'b1, data: '0, kind: mbs_pkg::KIND_HDONE};
         hold_in = 1'b0;
      end else if (cmd.go && cmd.feed) begin
         case (phase_ff)
            PH_START: begin
               if (pc_ff == 2'd0 && cmd.data == mbs_pkg::CHAR_CR) begin
                  pc_in = 2'd1;
               end else if (pc_ff == 2'd0 && cmd.data == mbs_pkg::CHAR_DASH) begin
                  pc_in = 2'd2;
               end else if (pc_ff == 2'd1 && cmd.data == mbs_pkg::CHAR_LF) begin
                  phase_in = PH_HEADERS;
                  pc_in    = 2'd0;
               end else if (pc_ff == 2'd2 && cmd.data == mbs_pkg::CHAR_DASH) begin
                  res      = '{valid: 1'b1, data: '0, kind: mbs_pkg::KIND_CLOSE};
                  phase_in = PH_FINISHED;
                  pc_in    = 2'd0;
               end else begin
                  res      = '{valid: 1'b1, data: '0, kind: mbs_pkg::KIND_MALFORMED};
                  phase_in = PH_DISCARD;
                  pc_in    = 2'd0;
               end
            end
            PH_HEADERS: begin
               res = '{valid: 1'b1, data: cmd.data, kind: mbs_pkg::KIND_HEADER};
               if (cmd.data == expect_byte) begin
                  if (pc_ff == 2'd3) begin
                     hold_in  = 1'b1;
                     phase_in = PH_BODY;
                     pc_in    = 2'd0;
                  end else begin
                     pc_in = pc_ff + 2'd1;
                  end
               end else begin
                  // a stray CR opens a new CR LF CR LF search
                  pc_in = (cmd.data == mbs_pkg::CHAR_CR) ? 2'd1 : 2'd0;
               end
            end
            PH_BODY: begin
               res = '{valid: 1'b1, data: cmd.data, kind: mbs_pkg::KIND_BODY};
            end
            default: begin
               // drop: discarding or message closed
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         pc_ff    <= 2'd0;
         hold_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pc_ff    <= pc_in;
         hold_ff  <= hold_in;
      end
   end

   assign status.hold     = hold_ff;
   assign status.finished = (phase_ff == PH_FINISHED);

   a_hold_in_body: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> (phase_ff == PH_BODY))
      else $error("headers-complete pending outside body phase");

endmodule

`default_nettype wire
